// File: hw/rtl/tstc_pkg.sv
// Package for the torus surface to Cartesian block.
// Holds CORDIC constants, the arctangent table and register indexes; no dependencies.
`timescale 1ns / 1ps
package tstc_pkg;

   localparam int CordicW = 34;
   localparam int PhaseW = 33;
   localparam logic signed [CordicW-1:0] GAIN_Q30 = 34'sd652032874;

   typedef enum logic [2:0] {
      REG_MAJOR  = 3'd0,
      REG_MINOR  = 3'd1,
      REG_U_LOW  = 3'd2,
      REG_U_HIGH = 3'd3,
      REG_V_LOW  = 3'd4,
      REG_V_HIGH = 3'd5
   } csr_index_type;

   function automatic logic [31:0] atan_phase(input int idx);
      logic [31:0] t;
      begin
         case (idx)
            0: t = 32'd536870912;  1: t = 32'd316933406;  2: t = 32'd167458907;
            3: t = 32'd85004756;   4: t = 32'd42667331;   5: t = 32'd21354465;
            6: t = 32'd10680862;   7: t = 32'd5340245;    8: t = 32'd2670163;
            9: t = 32'd1335087;   10: t = 32'd667544;    11: t = 32'd333772;
            12: t = 32'd166886;   13: t = 32'd83443;     14: t = 32'd41721;
            15: t = 32'd20860;    16: t = 32'd10430;     17: t = 32'd5215;
            18: t = 32'd2607;     19: t = 32'd1303;      20: t = 32'd651;
            21: t = 32'd325;      22: t = 32'd162;       23: t = 32'd81;
            24: t = 32'd40;       25: t = 32'd20;        26: t = 32'd10;
            27: t = 32'd5;        28: t = 32'd2;         29: t = 32'd1;
            default: t = 32'd0;
         endcase
         return t;
      end
   endfunction

endpackage

// File: hw/rtl/tstc_cordic.sv
// Pipelined rotation-mode CORDIC producing cosine and sine (Q.16) of an angle.
// Depends on tstc_pkg. One stage register per iteration, gated by a shared enable.
`timescale 1ns / 1ps
module tstc_cordic import tstc_pkg::*; #(
   parameter int ANGLE_BITS    = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic                         clock,
   input  logic                         enable,
   input  logic signed [ANGLE_BITS-1:0] angle,
   output logic signed [17:0]           cos_out,
   output logic signed [17:0]           sin_out
);
   localparam int Stages = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

   logic signed [CordicW-1:0] x_ff [Stages+1];
   logic signed [CordicW-1:0] y_ff [Stages+1];
   logic signed [PhaseW-1:0]  z_ff [Stages+1];
   logic                      flip_ff [Stages+1];

   logic [31:0] phase_in;
   logic [31:0] phase_rot;
   logic        flip_in;

   always_comb begin
      phase_in  = 32'(angle) << (32 - ANGLE_BITS);
      flip_in   = (phase_in[31:30] == 2'd1) || (phase_in[31:30] == 2'd2);
      phase_rot = flip_in ? (phase_in + 32'h8000_0000) : phase_in;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff[0]    <= GAIN_Q30;
         y_ff[0]    <= '0;
         z_ff[0]    <= PhaseW'(signed'(phase_rot));
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < Stages; i++) begin : g_stage
      logic signed [CordicW-1:0] dx, dy;
      logic signed [PhaseW-1:0]  step;
      assign dx   = y_ff[i] >>> i;
      assign dy   = x_ff[i] >>> i;
      assign step = PhaseW'(atan_phase(i));
      always_ff @(posedge clock) begin
         if (enable) begin
            flip_ff[i+1] <= flip_ff[i];
            if (!z_ff[i][PhaseW-1]) begin
               x_ff[i+1] <= x_ff[i] - dx;
               y_ff[i+1] <= y_ff[i] + dy;
               z_ff[i+1] <= z_ff[i] - step;
            end else begin
               x_ff[i+1] <= x_ff[i] + dx;
               y_ff[i+1] <= y_ff[i] - dy;
               z_ff[i+1] <= z_ff[i] + step;
            end
         end
      end
   end

   logic signed [CordicW-1:0] xf, yf, xr, yr;
   always_comb begin
      xf = flip_ff[Stages] ? -x_ff[Stages] : x_ff[Stages];
      yf = flip_ff[Stages] ? -y_ff[Stages] : y_ff[Stages];
      xr = (xf + CordicW'(8192)) >>> 14;
      yr = (yf + CordicW'(8192)) >>> 14;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cos_out <= xr[17:0];
         sin_out <= yr[17:0];
      end
   end
endmodule

// File: hw/rtl/tstc_mix.sv
// Combine stage: ring radius, then x/y/z products with rounding and saturation.
// Depends on tstc_pkg; four register stages gated by a shared enable.
`timescale 1ns / 1ps
module tstc_mix import tstc_pkg::*; #(
   parameter int RADIUS_BITS = 16
) (
   input  logic                   clock,
   input  logic                   enable,
   input  logic [RADIUS_BITS-1:0] major_radius,
   input  logic [RADIUS_BITS-1:0] minor_radius,
   input  logic                   err_in,
   input  logic signed [17:0]     cu,
   input  logic signed [17:0]     su,
   input  logic signed [17:0]     cv,
   input  logic signed [17:0]     sv,
   output logic signed [17:0]     x_pos,
   output logic signed [17:0]     y_pos,
   output logic signed [16:0]     z_pos,
   output logic                   window_miss
);
   localparam int RingW = RADIUS_BITS + 20;
   localparam int ProdW = RingW + 18;

   // stage A: r*cos v, r*sin v
   logic signed [RADIUS_BITS+18:0] rc_ff, rs_ff;
   logic signed [17:0] cu_a_ff, su_a_ff;
   logic [RADIUS_BITS-1:0] maj_a_ff;
   logic err_a_ff;
   // stage B: ring rounded
   logic signed [RingW-1:0] ring_ff;
   logic signed [17:0] cu_b_ff, su_b_ff;
   logic signed [RADIUS_BITS+18:0] zr_b_ff;
   logic err_b_ff;
   // stage C: products
   logic signed [ProdW-1:0] xp_ff, yp_ff;
   logic signed [RADIUS_BITS+18:0] zr_c_ff;
   logic err_c_ff;

   logic signed [RingW+12:0] ring_full;
   logic signed [RingW+12:0] ring_rnd;
   logic signed [ProdW-1:0]  xr, yr;
   logic signed [RADIUS_BITS+18:0] zr;

   always_comb begin
      ring_full = $signed({1'b0, maj_a_ff, 16'd0}) + rc_ff;
      ring_rnd  = (ring_full + (RingW+13)'(2048)) >>> 12;
      xr = (xp_ff + ProdW'(64'sd524288)) >>> 20;
      yr = (yp_ff + ProdW'(64'sd524288)) >>> 20;
      zr = (zr_c_ff + (RADIUS_BITS+19)'(32768)) >>> 16;
   end

   function automatic logic signed [17:0] sat18(input logic signed [ProdW-1:0] v);
      if (v > ProdW'(131071)) return 18'sd131071;
      else if (v < -ProdW'(131072)) return -18'sd131072;
      else return v[17:0];
   endfunction

   function automatic logic signed [16:0] sat17(input logic signed [RADIUS_BITS+18:0] v);
      if (v > (RADIUS_BITS+19)'(65535)) return 17'sd65535;
      else if (v < -(RADIUS_BITS+19)'(65536)) return -17'sd65536;
      else return v[16:0];
   endfunction

   always_ff @(posedge clock) begin
      if (enable) begin
         rc_ff    <= $signed({1'b0, minor_radius}) * cv;
         rs_ff    <= $signed({1'b0, minor_radius}) * sv;
         cu_a_ff  <= cu;
         su_a_ff  <= su;
         maj_a_ff <= major_radius;
         err_a_ff <= err_in;

         ring_ff  <= ring_rnd[RingW-1:0];
         cu_b_ff  <= cu_a_ff;
         su_b_ff  <= su_a_ff;
         zr_b_ff  <= rs_ff;
         err_b_ff <= err_a_ff;

         xp_ff    <= ring_ff * cu_b_ff;
         yp_ff    <= ring_ff * su_b_ff;
         zr_c_ff  <= zr_b_ff;
         err_c_ff <= err_b_ff;

         x_pos       <= err_c_ff ? '0 : sat18(xr);
         y_pos       <= err_c_ff ? '0 : sat18(yr);
         z_pos       <= err_c_ff ? '0 : sat17(zr);
         window_miss <= err_c_ff;
      end
   end
endmodule

// File: hw/rtl/torus_surface_to_cartesian.sv
// Torus surface coordinate to Cartesian point converter, top level.
// Depends on tstc_pkg, tstc_cordic and tstc_mix.
`timescale 1ns / 1ps
// Takes one (u, v) request per cycle and returns x, y, z of the torus point in
// Q8.8 units, with window_miss and zero outputs for coordinates outside the
// u/v windows. Results pass through the two parallel CORDIC pipelines
// (CORDIC_STAGES + 2 registers each, stage count capped at 32) and the
// four-stage product pipeline. The whole pipeline advances as one while
// the output register is empty or being taken, so a stalled result holds every
// stage. The user must write registers only while idle; the block does not enforce it.
module torus_surface_to_cartesian import tstc_pkg::*; #(
   parameter int ANGLE_BITS    = 16,
   parameter int RADIUS_BITS   = 16,
   parameter int CORDIC_STAGES = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [(2*ANGLE_BITS+7)/8*8-1:0] req_tdata,  // u_angle, v_angle
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,  // x_pos[17:0], y_pos[35:18], z_pos[52:36], window_miss[53]
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [((RADIUS_BITS > ANGLE_BITS) ? RADIUS_BITS : ANGLE_BITS)-1:0] csr_wdata
);
   localparam int Stages = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;
   localparam int Depth  = Stages + 5;

   logic [RADIUS_BITS-1:0] major_ff, minor_ff;
   logic signed [ANGLE_BITS-1:0] u_low_ff, u_high_ff, v_low_ff, v_high_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         major_ff  <= RADIUS_BITS'(256);
         minor_ff  <= RADIUS_BITS'(64);
         u_low_ff  <= {1'b1, {(ANGLE_BITS-1){1'b0}}};
         u_high_ff <= {1'b0, {(ANGLE_BITS-1){1'b1}}};
         v_low_ff  <= {1'b1, {(ANGLE_BITS-1){1'b0}}};
         v_high_ff <= {1'b0, {(ANGLE_BITS-1){1'b1}}};
      end else if (csr_we) begin
         case (csr_index)
            REG_MAJOR:  major_ff  <= csr_wdata[RADIUS_BITS-1:0];
            REG_MINOR:  minor_ff  <= csr_wdata[RADIUS_BITS-1:0];
            REG_U_LOW:  u_low_ff  <= csr_wdata[ANGLE_BITS-1:0];
            REG_U_HIGH: u_high_ff <= csr_wdata[ANGLE_BITS-1:0];
            REG_V_LOW:  v_low_ff  <= csr_wdata[ANGLE_BITS-1:0];
            REG_V_HIGH: v_high_ff <= csr_wdata[ANGLE_BITS-1:0];
            default: ;
         endcase
      end
   end

   logic signed [ANGLE_BITS-1:0] u_angle, v_angle;
   assign u_angle = req_tdata[ANGLE_BITS-1:0];
   assign v_angle = req_tdata[2*ANGLE_BITS-1:ANGLE_BITS];

   logic enable;
   logic [Depth:0] valid_ff;
   assign enable     = !valid_ff[Depth] || rsp_tready;
   assign req_tready = enable;
   assign rsp_tvalid = valid_ff[Depth];

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else if (enable) valid_ff <= {valid_ff[Depth-1:0], req_tvalid};
   end

   // range flag travels alongside the CORDIC stages
   logic err_in;
   logic [Stages+1:0] err_ff;
   assign err_in = (u_angle < u_low_ff) || (u_angle > u_high_ff) ||
                   (v_angle < v_low_ff) || (v_angle > v_high_ff);
   always_ff @(posedge clock) begin
      if (enable) err_ff <= {err_ff[Stages:0], err_in};
   end

   logic signed [17:0] cu, su, cv, sv;
   tstc_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_u (
      .clock(clock), .enable(enable), .angle(u_angle), .cos_out(cu), .sin_out(su));
   tstc_cordic #(.ANGLE_BITS(ANGLE_BITS), .CORDIC_STAGES(CORDIC_STAGES)) u_cordic_v (
      .clock(clock), .enable(enable), .angle(v_angle), .cos_out(cv), .sin_out(sv));

   logic signed [17:0] x_pos, y_pos;
   logic signed [16:0] z_pos;
   logic window_miss;
   tstc_mix #(.RADIUS_BITS(RADIUS_BITS)) u_mix (
      .clock(clock), .enable(enable),
      .major_radius(major_ff), .minor_radius(minor_ff),
      .err_in(err_ff[Stages+1]), .cu(cu), .su(su), .cv(cv), .sv(sv),
      .x_pos(x_pos), .y_pos(y_pos), .z_pos(z_pos), .window_miss(window_miss));

   assign rsp_tdata = {2'b00, window_miss, z_pos, y_pos, x_pos};
endmodule

// File: hw/rtl/tstc_checker.sv
// Port-level checker for torus_surface_to_cartesian, bound to the top level.
// Depends on nothing but the top level's ports.
`timescale 1ns / 1ps
module tstc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped or changed under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request refused with empty output");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[53] |-> rsp_tdata[52:0] == 53'd0)
      else $error("range error with nonzero coordinates");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[55:54] == 2'b00)
      else $error("padding bits set");
endmodule

bind torus_surface_to_cartesian tstc_checker u_tstc_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata));
